>>> hdl/kisr_pkg.sv
// Package for the key/index sorter: entry layout, field widths and register indexes.
// Used by the top level; has no dependencies of its own.
package kisr_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 1'd1;

    // One stored item: the arrival tag travels with its key.
    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> hdl/key_index_sort_with_reverse.sv
// Key sorter with arrival tags: loads one key per cycle, then sorts if enabled and emits
// the batch, forward or reversed. A batch end starts a gnome sort walk of compares and
// swaps on the shared RAM ports, then each result is read out and held while stalled.
// Throughput: one key per cycle while loading; no key is taken during sort or output.
// Reset (synchronous, active low) clears the count, walk, output index, state, flags and config.
// Depends on kisr_pkg and kisr_ram.
module key_index_sort_with_reverse #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kisr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kisr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [kisr_pkg::KEY_W-1:0]   i_sort_key,
    input  logic                                i_batch_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [kisr_pkg::TAG_W-1:0]          o_position_tag,
    output logic signed [kisr_pkg::KEY_W-1:0]   o_sorted_key,
    output logic                                o_final_item
);

    import kisr_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE       = CW'(1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_CMP      = 3'd2;
    localparam logic [2:0] S_SWAP     = 3'd3;
    localparam logic [2:0] S_OUT_RD   = 3'd4;
    localparam logic [2:0] S_OUT_LD   = 3'd5;
    localparam logic [2:0] S_OUT_WAIT = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_walk, n_walk;
    logic [CW-1:0] r_out_idx, n_out_idx;
    logic          r_sort_enable;
    logic          r_descending;
    t_entry        r_hold, n_hold;
    logic          r_out_valid, n_out_valid;
    logic          r_final, n_final;
    t_entry        r_out, n_out;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_entry             w_wdata;
    logic [AW-1:0]      w_raddr_a;
    logic [AW-1:0]      w_raddr_b;
    logic [ENTRY_W-1:0] w_rdata_a;
    logic [ENTRY_W-1:0] w_rdata_b;
    t_entry             w_ent_a;
    t_entry             w_ent_b;
    logic [CW-1:0]      w_walk_m1;
    logic [CW-1:0]      w_walk_p1;
    logic [CW-1:0]      w_src;
    logic [CW-1:0]      w_load_count;

    assign w_ent_a   = w_rdata_a;
    assign w_ent_b   = w_rdata_b;
    assign w_walk_m1 = r_walk - ONE;
    assign w_walk_p1 = r_walk + ONE;
    assign w_src     = r_descending ? (r_count - ONE - r_out_idx) : r_out_idx;
    assign w_load_count = (r_count < MAX_COUNT) ? (r_count + ONE) : r_count;

    kisr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign w_raddr_a = (r_state == S_READ) ? w_walk_m1[AW-1:0] : w_src[AW-1:0];
    assign w_raddr_b = r_walk[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_walk      = r_walk;
        n_out_idx   = r_out_idx;
        n_hold      = r_hold;
        n_out_valid = r_out_valid;
        n_final     = r_final;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata.tag = TAG_W'(r_count);
        w_wdata.key = i_sort_key;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Keys beyond capacity are dropped, but a batch end still counts.
                    w_we    = (r_count < MAX_COUNT);
                    n_count = w_load_count;
                    if (i_batch_end) begin
                        n_walk    = ONE;
                        n_out_idx = '0;
                        if (r_sort_enable && (w_load_count > ONE)) begin
                            n_state = S_READ;
                        end else begin
                            n_state = S_OUT_RD;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_ent_a.key <= w_ent_b.key) begin
                    n_walk = w_walk_p1;
                    if (w_walk_p1 == r_count) begin
                        n_walk  = ONE;
                        n_state = S_OUT_RD;
                    end else begin
                        n_state = S_READ;
                    end
                end else begin
                    // First half of the swap: the left entry moves right.
                    w_we    = 1'b1;
                    w_waddr = r_walk[AW-1:0];
                    w_wdata = w_ent_a;
                    n_hold  = w_ent_b;
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = w_walk_m1[AW-1:0];
                w_wdata = r_hold;
                // Stepping back from the first position restarts the walk at one.
                n_walk  = (r_walk == ONE) ? ONE : w_walk_m1;
                n_state = S_READ;
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out       = w_ent_a;
                n_final     = ((r_out_idx + ONE) == r_count);
                n_out_valid = 1'b1;
                n_state     = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_final) begin
                        n_count = '0;
                        n_walk  = ONE;
                        n_state = S_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + ONE;
                        n_state   = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_walk        <= ONE;
            r_out_idx     <= '0;
            r_out_valid   <= 1'b0;
            r_final       <= 1'b0;
            r_sort_enable <= 1'b0;
            r_descending  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_walk      <= n_walk;
            r_out_idx   <= n_out_idx;
            r_out_valid <= n_out_valid;
            r_final     <= n_final;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SORT_ENABLE: r_sort_enable <= i_cfg_data[0];
                    REG_DESCENDING:  r_descending  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_position_tag = r_out.tag;
    assign o_sorted_key   = r_out.key;
    assign o_final_item   = r_final;

endmodule

>>> hdl/kisr_ram.sv
// Generic RAM: one write port and two read ports, read data registered.
// No dependencies.
module kisr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> bench/kisr_checker.sv
// Checker for the key/index sorter: follows the register port and both channels, builds
// the expected result stream itself and compares it with what the block emits.
// Depends on kisr_pkg for the field widths, the entry layout and the register indexes.
module kisr_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kisr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kisr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [kisr_pkg::KEY_W-1:0]   i_sort_key,
    input  logic                                i_batch_end,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [kisr_pkg::TAG_W-1:0]          i_position_tag,
    input  logic signed [kisr_pkg::KEY_W-1:0]   i_sorted_key,
    input  logic                                i_final_item,
    output int                                  o_pending,
    output int                                  o_fail_count
);

    import kisr_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
        logic                    last;
    } t_result;

    logic     sort_on;
    logic     reverse_on;
    t_entry   arrivals[$];
    t_result  ordered_results[$];
    int       fails;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        fails        = 0;
        sort_on      = 1'b0;
        reverse_on   = 1'b0;
    end

    // Stable insertion sort gives the same order as the block's adjacent swap walk.
    function automatic void order_batch();
        t_entry  held;
        t_result res;
        int      n;
        int      j;
        int      src;
        n = arrivals.size();
        if (sort_on) begin
            for (int i = 1; i < n; i++) begin
                j = i;
                while (j > 0 && $signed(arrivals[j-1].key) > $signed(arrivals[j].key)) begin
                    held          = arrivals[j];
                    arrivals[j]   = arrivals[j-1];
                    arrivals[j-1] = held;
                    j--;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            src      = reverse_on ? (n - 1 - k) : k;
            res.tag  = arrivals[src].tag;
            res.key  = arrivals[src].key;
            res.last = (k == n - 1);
            ordered_results.push_back(res);
        end
        arrivals.delete();
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_entry  slot;
        if (!i_rst_n) begin
            sort_on    = 1'b0;
            reverse_on = 1'b0;
            arrivals.delete();
            ordered_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SORT_ENABLE: sort_on    = i_cfg_data[0];
                    REG_DESCENDING:  reverse_on = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (ordered_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("unexpected result transaction: tag %0d key %0d last %0b",
                                 i_position_tag, i_sorted_key, i_final_item);
                end else begin
                    want = ordered_results.pop_front();
                    if (i_position_tag !== want.tag || i_sorted_key !== want.key ||
                        i_final_item !== want.last) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $write("result mismatch: expected tag %0d key %0d last %0b,",
                                   want.tag, want.key, want.last);
                            $display(" got tag %0d key %0d last %0b",
                                     i_position_tag, i_sorted_key, i_final_item);
                        end
                    end
                end
            end

            // Keys past capacity are dropped, but their end marker still closes the batch.
            if (i_in_valid && !i_in_stall) begin
                if (arrivals.size() < MAX_ITEMS) begin
                    slot.tag = TAG_W'(arrivals.size());
                    slot.key = i_sort_key;
                    arrivals.push_back(slot);
                end
                if (i_batch_end)
                    order_batch();
            end
        end
        o_pending    <= ordered_results.size();
        o_fail_count <= fails;
    end

endmodule

>>> bench/tb_key_index_sort_with_reverse.sv
// Testbench top for key_index_sort_with_reverse: drives batches of keys and register writes
// with random gaps and output stalls, and gives the verdict from kisr_checker's count.
// Depends on kisr_pkg, the block under test and kisr_checker.
module tb_key_index_sort_with_reverse;

    import kisr_pkg::*;

    localparam int MAX_ITEMS    = 64;
    localparam int RANDOM_ITEMS = 230;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 20;
    // Must outlast the worst sort walk, in which nothing is accepted.
    localparam int IDLE_LIMIT   = 40000;

    localparam logic signed [KEY_W-1:0] MIN_KEY = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] MAX_KEY = 32'sh7FFF_FFFF;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic signed [KEY_W-1:0] i_sort_key = '0;
    logic                    i_batch_end = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [TAG_W-1:0]        o_position_tag;
    logic signed [KEY_W-1:0] o_sorted_key;
    logic                    o_final_item;

    int pending;
    int fail_count;
    int keys_sent = 0;
    int idle_cycles = 0;
    int stall_run = 0;

    key_index_sort_with_reverse #(
        .MAX_ITEMS(MAX_ITEMS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sort_key     (i_sort_key),
        .i_batch_end    (i_batch_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_position_tag (o_position_tag),
        .o_sorted_key   (o_sorted_key),
        .o_final_item   (o_final_item)
    );

    kisr_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sort_key     (i_sort_key),
        .i_batch_end    (i_batch_end),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_position_tag (o_position_tag),
        .i_sorted_key   (o_sorted_key),
        .i_final_item   (o_final_item),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output stall comes in runs: short stalls mostly, a few long ones, and some long free stretches.
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (!i_out_stall && $urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            stall_run   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
            stall_run   <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 8);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[key_index_sort_with_reverse] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        else if (r < 8)
            return $signed($urandom_range(0, 8)) - 4;
        else if (r == 8)
            return MIN_KEY + $urandom_range(0, 1);
        return MAX_KEY - $urandom_range(0, 1);
    endfunction

    function automatic logic pick_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Each task starts and returns just after a rising edge.
    task automatic send_key(input logic signed [KEY_W-1:0] key, input logic last,
                            input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sort_key  <= key;
        i_batch_end <= last;
        do @(posedge i_clk); while (o_in_stall);
        keys_sent++;
    endtask

    // Holds the sender back until every result of earlier batches has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic sort_on, input logic reverse_on);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SORT_ENABLE;
        i_cfg_data  <= sort_on;
        @(posedge i_clk);
        i_cfg_index <= REG_DESCENDING;
        i_cfg_data  <= reverse_on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_batch(input int count, input bit no_gap);
        for (int i = 0; i < count; i++)
            send_key(pick_key(), i == count - 1, no_gap);
    endtask

    initial begin
        int  first_random;
        int  batch_no;
        int  count;
        int  r;
        bit  no_gap;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings keep arrival order.
        send_key(MIN_KEY, 1'b0, 1'b0);
        send_key(MAX_KEY, 1'b0, 1'b0);
        send_key(0, 1'b1, 1'b0);
        drain();

        set_mode(1'b1, 1'b0);
        send_key(-1, 1'b1, 1'b0);
        send_key(5, 1'b0, 1'b1);
        send_key(-3, 1'b0, 1'b1);
        send_key(5, 1'b0, 1'b1);
        send_key(MIN_KEY, 1'b0, 1'b1);
        send_key(MAX_KEY, 1'b0, 1'b1);
        send_key(-1, 1'b1, 1'b1);
        drain();

        // Equal keys under a descending sort come out in reversed arrival order.
        set_mode(1'b1, 1'b1);
        send_key(7, 1'b0, 1'b0);
        send_key(7, 1'b0, 1'b0);
        send_key(MIN_KEY, 1'b0, 1'b0);
        send_key(7, 1'b0, 1'b0);
        send_key(MAX_KEY, 1'b1, 1'b0);
        drain();

        set_mode(1'b0, 1'b1);
        send_key(1, 1'b0, 1'b0);
        send_key(2, 1'b0, 1'b0);
        send_key(3, 1'b1, 1'b0);

        first_random = keys_sent;
        batch_no     = 0;
        while (keys_sent - first_random < RANDOM_ITEMS) begin
            if (batch_no == 2) begin
                // Full batch in falling key order, the longest sort walk, then two keys
                // past capacity with the end marker on the last ignored one.
                drain();
                set_mode(1'b1, pick_bit());
                for (int i = 0; i < MAX_ITEMS; i++)
                    send_key(32'sd1000000 - i * 32'sd12345, 1'b0, 1'b0);
                send_key(pick_key(), 1'b0, 1'b0);
                send_key(pick_key(), 1'b1, 1'b0);
            end else if (batch_no == 9) begin
                drain();
                set_mode(pick_bit(), pick_bit());
                send_batch(MAX_ITEMS, 1'b0);
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    drain();
                    set_mode(pick_bit(), pick_bit());
                end
                r = $urandom_range(0, 9);
                if (r < 7)
                    count = $urandom_range(1, 8);
                else if (r < 9)
                    count = $urandom_range(9, 30);
                else
                    count = $urandom_range(31, 63);
                no_gap = ($urandom_range(0, 3) == 0);
                send_batch(count, no_gap);
            end
            batch_no++;
        end

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (TAIL) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[key_index_sort_with_reverse] OK");
        else
            $display("[key_index_sort_with_reverse] ERROR");
        $finish;
    end

endmodule
